### hdl/sbsm_pkg.sv
`timescale 1ns / 1ps

package sbsm_pkg;

  localparam int PRG_OFS_W  = 19;
  localparam int RAM_OFS_W  = 13;
  localparam int REG_W      = 5;
  localparam int BANK_PAGE_W = 14;  // 16KB PRG page

  localparam logic [REG_W-1:0] CTRL_RESET  = 5'h0C;
  localparam logic [REG_W-1:0] CTRL_PRG_FIX = 5'h0C;  // OR'd in on a serial reset beat
  localparam logic [2:0]       SHIFT_LEN   = 3'd5;
  localparam logic [3:0]       LAST_BANK   = 4'hF;

  typedef enum logic [2:0] {
    KIND_ROM_READ  = 3'd0,
    KIND_RAM_READ  = 3'd1,
    KIND_RAM_WRITE = 3'd2,
    KIND_REG_WRITE = 3'd3,
    KIND_IGNORED   = 3'd4
  } kind_t;

  // PRG banking mode, control bits 3:2
  typedef enum logic [1:0] {
    PRG_32K_A    = 2'd0,
    PRG_32K_B    = 2'd1,
    PRG_FIX_LOW  = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } prg_mode_t;

  // target of a serial commit, address bits 14:13
  typedef enum logic [1:0] {
    TGT_CONTROL = 2'd0,
    TGT_CHR0    = 2'd1,
    TGT_CHR1    = 2'd2,
    TGT_PRG     = 2'd3
  } target_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    kind_t                access_kind;
    logic [PRG_OFS_W-1:0] prg_rom_offset;
    logic [RAM_OFS_W-1:0] ram_offset;
    logic [1:0]           nt_mirror;
    logic [REG_W-1:0]     chr_bank_lower;
    logic [REG_W-1:0]     chr_bank_upper;
  } rsp_t;

  typedef struct packed {
    logic [REG_W-1:0] control;
    logic [REG_W-1:0] prg_bank;
    logic [REG_W-1:0] chr0;
    logic [REG_W-1:0] chr1;
  } map_state_t;

endpackage

### hdl/sbsm_chan_if.sv
`timescale 1ns / 1ps

interface sbsm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/sbsm_loader.sv
`timescale 1ns / 1ps

// Serial port: five data beats build a value, the fifth commits it.
module sbsm_loader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  sbsm_pkg::req_t      req,
  output sbsm_pkg::map_state_t state_r,
  output sbsm_pkg::map_state_t state_nxt,
  output logic [2:0]          bit_cnt
);

  logic [sbsm_pkg::REG_W-1:0] shift_r, shift_nxt, shift_in;
  logic [2:0]                 cnt_r, cnt_nxt, cnt_inc;
  logic                       reg_wr;

  assign reg_wr   = adv && req.req_type && req.cpu_address[15];
  assign shift_in = {req.write_data[0], shift_r[sbsm_pkg::REG_W-1:1]};
  assign cnt_inc  = cnt_r + 3'd1;
  assign bit_cnt  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    if (reg_wr) begin
      if (req.write_data[7]) begin
        state_nxt.control = state_r.control | sbsm_pkg::CTRL_PRG_FIX;
        shift_nxt = '0;
        cnt_nxt   = '0;
      end else if (cnt_inc >= sbsm_pkg::SHIFT_LEN) begin
        unique case (sbsm_pkg::target_t'(req.cpu_address[14:13]))
          sbsm_pkg::TGT_CONTROL: state_nxt.control  = shift_in;
          sbsm_pkg::TGT_CHR0:    state_nxt.chr0     = shift_in;
          sbsm_pkg::TGT_CHR1:    state_nxt.chr1     = shift_in;
          sbsm_pkg::TGT_PRG:     state_nxt.prg_bank = shift_in;
          default:               state_nxt.prg_bank = shift_in;
        endcase
        shift_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        shift_nxt = shift_in;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.control  <= sbsm_pkg::CTRL_RESET;
      state_r.prg_bank <= '0;
      state_r.chr0     <= '0;
      state_r.chr1     <= '0;
      shift_r          <= '0;
      cnt_r            <= '0;
    end else begin
      state_r <= state_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hdl/sbsm_map.sv
`timescale 1ns / 1ps

// Access decode and address translation for one bus beat.
module sbsm_map #(
  parameter int PRG_OFFSET_BITS = 19
) (
  input  sbsm_pkg::req_t       req,
  input  logic                 large_rom,
  input  sbsm_pkg::map_state_t st_pre,
  input  sbsm_pkg::map_state_t st_post,
  output sbsm_pkg::rsp_t       rsp
);

  localparam int BANK_W = PRG_OFFSET_BITS - sbsm_pkg::BANK_PAGE_W;

  logic [3:0]                 bank4;
  logic [4:0]                 bank5;
  logic                       high_half;
  logic [PRG_OFFSET_BITS-1:0] ofs;
  logic                       ram_on;
  logic                       is_ram;

  assign high_half = req.cpu_address[14];
  assign ram_on    = !st_pre.prg_bank[4];
  assign is_ram    = (req.cpu_address[15:13] == 3'b011) && ram_on;

  always_comb begin
    unique case (sbsm_pkg::prg_mode_t'(st_pre.control[3:2]))
      sbsm_pkg::PRG_32K_A,
      sbsm_pkg::PRG_32K_B:    bank4 = {st_pre.prg_bank[3:1], high_half};
      sbsm_pkg::PRG_FIX_LOW:  bank4 = high_half ? st_pre.prg_bank[3:0] : 4'h0;
      sbsm_pkg::PRG_FIX_HIGH: bank4 = high_half ? sbsm_pkg::LAST_BANK : st_pre.prg_bank[3:0];
      default:                bank4 = 4'h0;
    endcase
    // upper 256K select: +16 banks, bank4 never exceeds 15
    bank5 = {large_rom && st_pre.chr0[4], bank4};
  end

  assign ofs = {bank5[BANK_W-1:0], req.cpu_address[sbsm_pkg::BANK_PAGE_W-1:0]};

  always_comb begin
    rsp = '0;
    rsp.access_kind = sbsm_pkg::KIND_IGNORED;
    if (req.cpu_address[15]) begin
      if (req.req_type) begin
        rsp.access_kind = sbsm_pkg::KIND_REG_WRITE;
      end else begin
        rsp.access_kind = sbsm_pkg::KIND_ROM_READ;
        rsp.prg_rom_offset[PRG_OFFSET_BITS-1:0] = ofs;
      end
    end else if (is_ram) begin
      rsp.access_kind = req.req_type ? sbsm_pkg::KIND_RAM_WRITE : sbsm_pkg::KIND_RAM_READ;
      rsp.ram_offset  = req.cpu_address[sbsm_pkg::RAM_OFS_W-1:0];
    end

    // mirroring and CHR banking reflect the state after this beat
    rsp.nt_mirror = st_post.control[1:0];
    if (st_post.control[4] && !large_rom) begin
      rsp.chr_bank_lower = st_post.chr0;
      rsp.chr_bank_upper = st_post.chr1;
    end else begin
      rsp.chr_bank_lower = {st_post.chr0[4:1], 1'b0};
      rsp.chr_bank_upper = {st_post.chr0[4:1], 1'b1};
    end
  end

endmodule

### hdl/serial_loaded_bank_switch_mapper.sv
`timescale 1ns / 1ps

// Serial-loaded bank switch mapper. Takes one CPU bus beat per cycle on in_bus unless out_bus
// stalls, and returns one result beat per access on out_bus, in order. Throughput is one access
// per clock while out_bus is not stalled. Acceptance loads the input register; the result
// register, fed by decode and bank add, loads when out_bus can take it and sets out_bus.valid.
// Writes at 0x8000 and up drive the 5-bit serial loader; its register updates are visible
// to the very next access.
// cfg_bus sets large_rom and must only be written while no access is in flight.
module serial_loaded_bank_switch_mapper #(
  parameter int PRG_OFFSET_BITS = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  sbsm_chan_if.sink   in_bus,
  sbsm_chan_if.source out_bus,
  sbsm_chan_if.sink   cfg_bus
);

  sbsm_pkg::req_t       req_r;
  logic                 s1_v_r;
  sbsm_pkg::rsp_t       rsp, rsp_r;
  logic                 out_v_r;
  logic                 large_rom_r;
  logic                 adv;
  logic                 reg_wr;
  logic [2:0]           bit_cnt;
  sbsm_pkg::map_state_t st_r, st_nxt;

  assign adv           = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready  = !s1_v_r || adv;
  assign out_bus.valid = out_v_r;
  assign out_bus.data  = rsp_r;
  assign cfg_bus.ready = 1'b1;
  assign reg_wr        = adv && req_r.req_type && req_r.cpu_address[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      large_rom_r <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_bus.valid) begin
        large_rom_r <= cfg_bus.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      req_r <= in_bus.data;
    end
    if (adv) begin
      rsp_r <= rsp;
    end
  end

  sbsm_loader u_loader (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req       (req_r),
    .state_r   (st_r),
    .state_nxt (st_nxt),
    .bit_cnt   (bit_cnt)
  );

  sbsm_map #(
    .PRG_OFFSET_BITS (PRG_OFFSET_BITS)
  ) u_map (
    .req       (req_r),
    .large_rom (large_rom_r),
    .st_pre    (st_r),
    .st_post   (st_nxt),
    .rsp       (rsp)
  );

  // serial loader commits on the fifth beat, so the count never reaches five
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt <= 3'd4)
    else $error("serial bit count out of range");

  // only a mapper register write may move the banking state
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !reg_wr |=> $stable(st_r))
    else $error("banking state changed without a register write");

  // ROM offset is only nonzero on a ROM read
  a_rom_ofs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (rsp_r.access_kind != sbsm_pkg::KIND_ROM_READ) |-> rsp_r.prg_rom_offset == '0)
    else $error("ROM offset set on a non-ROM access");

  // RAM offset is only nonzero on a RAM access
  a_ram_ofs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (rsp_r.access_kind != sbsm_pkg::KIND_RAM_READ)
      && (rsp_r.access_kind != sbsm_pkg::KIND_RAM_WRITE) |-> rsp_r.ram_offset == '0)
    else $error("RAM offset set on a non-RAM access");

endmodule
